// File: rtl/rmb_pkg.sv
// Shared types, codes and widths for the region-mapped memory bus.
package rmb_pkg;

  localparam int unsigned NUM_REGION_REGS = 4;
  localparam int unsigned LAST_HIT_SLOTS  = 4;
  localparam int unsigned BASE_W          = 24;
  localparam int unsigned SIZE_W          = 14;
  localparam int unsigned ADDR_W_MAX      = 24;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned REG_W           = 40;
  localparam int unsigned STORE_DEPTH     = 65536;
  localparam int unsigned STORE_AW        = 16;
  localparam int unsigned CFG_IDX_W       = 3;

  localparam int unsigned DEF_REGION_COUNT = 4;
  localparam int unsigned DEF_REGION_BYTES = 16384;
  localparam int unsigned DEF_ADDR_WIDTH   = 24;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FORCE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    W_BYTE = 2'd0,
    W_HALF = 2'd1,
    W_WORD = 2'd2,
    W_WIDE = 2'd3
  } width_t;

  typedef enum logic [1:0] {
    SLOT_FORCE = 2'd0,
    SLOT_READ  = 2'd1,
    SLOT_WRITE = 2'd2,
    SLOT_SPARE = 2'd3
  } slot_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FILL_IDX = 3'd4;
  localparam logic [2:0]           NO_REGION    = 3'd4;
  localparam logic [7:0]           FILL_RESET   = 8'hff;

  typedef struct packed {
    logic              ro;
    logic              active;
    logic [SIZE_W-1:0] size_m1;
    logic [BASE_W-1:0] base;
  } region_t;

  typedef struct packed {
    logic                hit;
    logic                scan_hit;
    logic [1:0]          region;
    logic                ro;
    logic                split;
    logic [STORE_AW-1:0] idx;
  } dec_res_t;

endpackage

// File: rtl/region_mapped_memory_bus.sv
// Bus access engine: region decode, split byte accesses, partitioned byte store.
// Mapped reads and writes not dropped whole as read-only walk their n bytes in S_BYTE
//   before the result is formed; unmapped, forced, no-op and non-split read-only writes
//   go from the lookup straight to the result. One access at a time, set by the single-
//   port store and the decoder shared by each byte: input stalls until the result loads.
// Reset clears control state, the regions to 0, the fill byte to 0xff and the
//   last-hit slots to empty; the byte store is not cleared and needs no pass.
module region_mapped_memory_bus import rmb_pkg::*; #(
  parameter int unsigned REGION_COUNT = DEF_REGION_COUNT,
  parameter int unsigned REGION_BYTES = DEF_REGION_BYTES,
  parameter int unsigned ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_operation,
  input  logic [1:0]            in_access_width,
  input  logic                  in_big_endian,
  input  logic [ADDR_W_MAX-1:0] in_address,
  input  logic [DATA_W-1:0]     in_write_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     out_read_data,
  output logic [2:0]            out_first_region,
  output logic                  out_write_blocked
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_BYTE = 5'b00100,
    S_WAIT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  region_t [NUM_REGION_REGS-1:0] region_r;
  logic [7:0]                    fill_r;
  logic [2:0]                    last_hit_r [LAST_HIT_SLOTS];

  op_t                  op_r, op_nxt;
  logic [1:0]           span_r, span_nxt;
  logic                 be_r, be_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0]    wd_r, wd_nxt;
  logic [1:0]           idx_r, idx_nxt;
  logic                 split_r, split_nxt;
  logic [STORE_AW-1:0]  base_idx_r, base_idx_nxt;
  logic [DATA_W-1:0]    rd_r, rd_nxt;
  logic [2:0]           first_r, first_nxt;
  logic                 blocked_r, blocked_nxt;
  logic                 pend_r, pend_nxt;
  logic [1:0]           pend_lane_r, pend_lane_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_rd_r;
  logic [2:0]           out_first_r;
  logic                 out_blocked_r;
  logic                 out_load;

  logic [7:0]           store_mem [STORE_DEPTH];
  logic [7:0]           mem_q_r;
  logic                 mem_we;
  logic [STORE_AW-1:0]  mem_addr;
  logic [7:0]           mem_wd;

  slot_t                slot;
  logic [ADDR_WIDTH-1:0] byte_addr;
  logic [1:0]           lane;
  dec_res_t             dec;
  logic                 slot_upd;
  logic                 in_xfer;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign byte_addr = addr_r + ADDR_WIDTH'(idx_r);
  assign lane      = be_r ? (span_r - idx_r) : idx_r;

  always_comb begin
    case (op_r)
      OP_READ:  slot = SLOT_READ;
      OP_WRITE: slot = SLOT_WRITE;
      default:  slot = SLOT_FORCE;
    endcase
  end

  rmb_decode #(
    .REGION_COUNT (REGION_COUNT),
    .REGION_BYTES (REGION_BYTES),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_decode (
    .regions (region_r),
    .addr    (byte_addr),
    .cached  (last_hit_r[slot]),
    .span    (span_r),
    .res     (dec)
  );

  assign slot_upd = dec.scan_hit &&
                    (((state_r == S_LOOK) && (op_r != OP_NONE)) ||
                     ((state_r == S_BYTE) && split_r));

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    span_nxt      = span_r;
    be_nxt        = be_r;
    addr_nxt      = addr_r;
    wd_nxt        = wd_r;
    idx_nxt       = idx_r;
    split_nxt     = split_r;
    base_idx_nxt  = base_idx_r;
    rd_nxt        = rd_r;
    first_nxt     = first_r;
    blocked_nxt   = blocked_r;
    pend_nxt      = 1'b0;
    pend_lane_nxt = pend_lane_r;
    mem_we        = 1'b0;
    mem_addr      = base_idx_r + STORE_AW'(idx_r);
    mem_wd        = 8'(wd_r >> {lane, 3'b000});
    out_load      = 1'b0;

    // merge the byte read issued last cycle
    if (pend_r) begin
      rd_nxt = rd_nxt | (DATA_W'(mem_q_r) << {pend_lane_r, 3'b000});
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt      = op_t'(in_operation);
          be_nxt      = in_big_endian;
          addr_nxt    = in_address[ADDR_WIDTH-1:0];
          wd_nxt      = in_write_data;
          idx_nxt     = '0;
          rd_nxt      = '0;
          first_nxt   = NO_REGION;
          blocked_nxt = 1'b0;
          case (width_t'(in_access_width))
            W_BYTE:  span_nxt = 2'd0;
            W_HALF:  span_nxt = 2'd1;
            default: span_nxt = 2'd3;
          endcase
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (op_r != OP_NONE) begin
          first_nxt = dec.hit ? {1'b0, dec.region} : NO_REGION;
        end
        base_idx_nxt = dec.idx;
        split_nxt    = dec.split;
        state_nxt    = S_DONE;
        case (op_r)
          OP_READ: begin
            if (!dec.hit) begin
              case (span_r)
                2'd0:    rd_nxt = DATA_W'(fill_r);
                2'd1:    rd_nxt = DATA_W'({fill_r, fill_r});
                default: rd_nxt = {4{fill_r}};
              endcase
            end else begin
              state_nxt = S_BYTE;
            end
          end
          OP_WRITE: begin
            if (dec.hit) begin
              if (!dec.split && dec.ro) begin
                blocked_nxt = 1'b1;
              end else begin
                state_nxt = S_BYTE;
              end
            end
          end
          OP_FORCE: begin
            mem_addr = dec.idx;
            mem_wd   = wd_r[7:0];
            mem_we   = dec.hit;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_BYTE: begin
        if (split_r) begin
          mem_addr = dec.idx;
          if (op_r == OP_READ) begin
            if (dec.hit) begin
              pend_nxt = 1'b1;
            end else begin
              rd_nxt = rd_nxt | (DATA_W'(fill_r) << {lane, 3'b000});
            end
          end else begin
            mem_we = dec.hit && !dec.ro;
            if (dec.hit && dec.ro) blocked_nxt = 1'b1;
          end
        end else begin
          if (op_r == OP_READ) begin
            pend_nxt = 1'b1;
          end else begin
            mem_we = 1'b1;
          end
        end
        pend_lane_nxt = lane;
        if (idx_r == span_r) begin
          state_nxt = S_WAIT;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      region_r    <= '0;
      fill_r      <= FILL_RESET;
      for (int s = 0; s < LAST_HIT_SLOTS; s++) last_hit_r[s] <= NO_REGION;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      if (cfg_write_en) begin
        if (cfg_index < CFG_IDX_W'(NUM_REGION_REGS)) begin
          region_r[cfg_index[1:0]] <= region_t'(cfg_data);
        end else if (cfg_index == CFG_FILL_IDX) begin
          fill_r <= cfg_data[7:0];
        end
      end
      if (slot_upd) last_hit_r[slot] <= {1'b0, dec.region};
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    span_r      <= span_nxt;
    be_r        <= be_nxt;
    addr_r      <= addr_nxt;
    wd_r        <= wd_nxt;
    idx_r       <= idx_nxt;
    split_r     <= split_nxt;
    base_idx_r  <= base_idx_nxt;
    rd_r        <= rd_nxt;
    first_r     <= first_nxt;
    blocked_r   <= blocked_nxt;
    pend_lane_r <= pend_lane_nxt;
    if (out_load) begin
      out_rd_r      <= rd_r;
      out_first_r   <= first_r;
      out_blocked_r <= blocked_r;
    end
  end

  // single-port byte store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_addr] <= mem_wd;
    mem_q_r <= store_mem[mem_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rd_r;
  assign out_first_region  = out_first_r;
  assign out_write_blocked = out_blocked_r;

  a_we_in_access: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_LOOK || state_r == S_BYTE))
    else $error("store written outside an access");

  a_no_pend_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !pend_r)
    else $error("byte read still pending when result is formed");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised without a finished access");

  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BYTE) |-> (idx_r <= span_r))
    else $error("byte counter ran past the access width");

endmodule

// File: rtl/rmb_decode.sv
// Region decoder: cached-slot check, priority scan, split test and store index.
module rmb_decode import rmb_pkg::*; #(
  parameter int unsigned REGION_COUNT = DEF_REGION_COUNT,
  parameter int unsigned REGION_BYTES = DEF_REGION_BYTES,
  parameter int unsigned ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
  input  region_t [NUM_REGION_REGS-1:0] regions,
  input  logic [ADDR_WIDTH-1:0]         addr,
  input  logic [2:0]                    cached,
  input  logic [1:0]                    span,
  output dec_res_t                      res
);

  localparam int unsigned SizeMax = REGION_BYTES - 1;

  logic [BASE_W:0]              addr_ext;
  logic [BASE_W:0]              end_v [NUM_REGION_REGS];
  logic [NUM_REGION_REGS-1:0]   hitv;
  logic [1:0]                   scan_r;
  logic                         cache_hit;
  logic                         scan_any;
  logic [1:0]                   sel;
  logic [BASE_W:0]              offset;

  assign addr_ext = (BASE_W + 1)'(addr);

  always_comb begin
    logic [SIZE_W-1:0] sm1;
    for (int r = 0; r < NUM_REGION_REGS; r++) begin
      sm1 = (regions[r].size_m1 > SIZE_W'(SizeMax)) ? SIZE_W'(SizeMax) : regions[r].size_m1;
      end_v[r] = {1'b0, regions[r].base} + (BASE_W + 1)'(sm1);
      hitv[r]  = (r < REGION_COUNT) && regions[r].active &&
                 (addr_ext >= {1'b0, regions[r].base}) && (addr_ext <= end_v[r]);
    end
  end

  // lowest region number wins the scan
  always_comb begin
    scan_r = '0;
    for (int r = NUM_REGION_REGS - 1; r >= 0; r--) begin
      if (hitv[r]) scan_r = 2'(r);
    end
  end

  assign scan_any  = |hitv;
  assign cache_hit = !cached[2] && hitv[cached[1:0]];
  assign sel       = cache_hit ? cached[1:0] : scan_r;
  assign offset    = addr_ext - {1'b0, regions[sel].base};

  always_comb begin
    res.hit      = cache_hit || scan_any;
    res.scan_hit = !cache_hit && scan_any;
    res.region   = sel;
    res.ro       = regions[sel].ro;
    res.split    = (addr_ext + (BASE_W + 1)'(span)) > end_v[sel];
    res.idx      = STORE_AW'(32'(sel) * REGION_BYTES) + offset[STORE_AW-1:0];
  end

endmodule
